// ----- rtl/core/apu_pkg.sv -----
// ----------------------------------------------------------------------------
// apu_pkg
// Shared types and constants of the Adam parameter update core.
// ----------------------------------------------------------------------------
package apu_pkg;

   typedef enum logic [1:0] {
      CMD_RESTART = 2'd0,
      CMD_LOSS    = 2'd1,
      CMD_GRAD    = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_CONTINUE  = 2'd0,
      STATUS_CONVERGED = 2'd1,
      STATUS_LIMIT     = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CSR_LEARNING_RATE  = 3'd0,
      CSR_TOLERANCE      = 3'd1,
      CSR_FIRST_DECAY    = 3'd2,
      CSR_SECOND_DECAY   = 3'd3,
      CSR_MAX_ITERATIONS = 3'd4
   } csr_index_type;

   typedef enum logic {
      DS_SQRT = 1'b0,
      DS_DIV  = 1'b1
   } ds_op_type;

   typedef struct packed {
      logic      start;
      ds_op_type op;
   } ds_req_type;

   localparam logic [46:0] LR_RESET      = 47'd42949673;
   localparam logic [46:0] TOL_RESET     = 47'd4295;
   localparam logic [31:0] B1_RESET      = 32'd3865470566;
   localparam logic [31:0] B2_RESET      = 32'd4252017623;
   localparam logic [15:0] MAXIT_RESET   = 16'd1000;
   localparam logic [31:0] POWER_ONE     = 32'hFFFF_FFFF;
   localparam logic [32:0] Q_ONE         = 33'h1_0000_0000;
   localparam logic [47:0] SAT_MAX       = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] SAT_MIN       = 48'h8000_0000_0000;
   localparam logic [41:0] EPS_Q         = 42'd43;
   localparam logic [48:0] MAG_LIMIT     = 49'h1_0000_0000_0000;

endpackage

// ----- rtl/core/apu_mul.sv -----
// ----------------------------------------------------------------------------
// apu_mul
// Unsigned 64 x 64 multiplier, one 32 x 32 partial product per cycle.
// ----------------------------------------------------------------------------
module apu_mul
   import apu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [63:0]  a,
   input  logic [63:0]  b,
   output logic         done,
   output logic [127:0] prod
);

   logic [63:0]  a_ff, a_in, b_ff, b_in;
   logic [127:0] acc_ff, acc_in;
   logic [1:0]   step_ff, step_in;
   logic         busy_ff, busy_in, done_ff, done_in;
   logic [31:0]  a_half, b_half;
   logic [63:0]  pp;
   logic [127:0] pp_ext;

   always_comb begin
      a_half = step_ff[0] ? a_ff[63:32] : a_ff[31:0];
      b_half = step_ff[1] ? b_ff[63:32] : b_ff[31:0];
      pp     = a_half * b_half;
      case (step_ff) inside
         2'd0:       pp_ext = {64'd0, pp};
         2'd1, 2'd2: pp_ext = {32'd0, pp, 32'd0};
         default:    pp_ext = {pp, 64'd0};
      endcase
   end

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = a;
         b_in    = b;
         acc_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in  = acc_ff + pp_ext;
         step_in = step_ff + 2'd1;
         if (step_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      acc_ff  <= acc_in;
      step_ff <= step_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

// ----- rtl/core/apu_divsqrt.sv -----
// ----------------------------------------------------------------------------
// apu_divsqrt
// Shared iterative unit: 128 / 64 restoring division, one quotient bit per
// cycle, and square root of radicand * 2^32, one root bit per cycle.
// ----------------------------------------------------------------------------
module apu_divsqrt
   import apu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  ds_req_type   ctl,
   input  logic [127:0] dividend,
   input  logic [63:0]  divisor,
   input  logic [47:0]  radicand,
   output logic         done,
   output logic [63:0]  result
);

   localparam logic [6:0] DIV_LAST  = 7'd63;
   localparam logic [6:0] SQRT_LAST = 7'd40;

   ds_op_type   op_ff, op_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [64:0] rem_ff, rem_in;
   logic [81:0] shf_ff, shf_in;
   logic [63:0] q_ff, q_in, dvs_ff, dvs_in;
   logic [64:0] trial, sub;
   logic        ge;

   always_comb begin
      if (op_ff == DS_DIV) begin
         trial = {rem_ff[63:0], shf_ff[81]};
         sub   = {1'b0, dvs_ff};
      end else begin
         trial = {rem_ff[62:0], shf_ff[81:80]};
         sub   = {1'b0, q_ff[61:0], 2'b01};
      end
      ge = trial >= sub;
   end

   always_comb begin
      op_in   = op_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      shf_in  = shf_ff;
      q_in    = q_ff;
      dvs_in  = dvs_ff;
      if (ctl.start) begin
         op_in  = ctl.op;
         q_in   = '0;
         rem_in = '0;
         if (ctl.op == DS_DIV) begin
            dvs_in = divisor;
            if (dividend[127:64] >= divisor) begin
               q_in    = '1;
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               rem_in  = {1'b0, dividend[127:64]};
               shf_in  = {dividend[63:0], 18'd0};
               cnt_in  = DIV_LAST;
               busy_in = 1'b1;
            end
         end else begin
            shf_in  = {2'b00, radicand, 32'd0};
            cnt_in  = SQRT_LAST;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in = ge ? trial - sub : trial;
         q_in   = {q_ff[62:0], ge};
         shf_in = (op_ff == DS_DIV) ? {shf_ff[80:0], 1'b0} : {shf_ff[79:0], 2'b00};
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      shf_ff <= shf_in;
      q_ff   <= q_in;
      dvs_ff <= dvs_in;
   end

   assign done   = done_ff;
   assign result = q_ff;

endmodule

// ----- rtl/core/adam_parameter_update_core.sv -----
// ----------------------------------------------------------------------------
// adam_parameter_update_core
// Adam optimizer step in signed Q15.32 with a stop rule on the loss.
//
// Items arrive on the req stream (tuser = command) and each gives exactly
// one rsp item (tuser = status, tdata = new parameter and iteration count).
// A restart clears both moments of every slot, the iteration count, the
// stored loss and the decay powers. A loss item checks the iteration limit
// and the loss change, then advances the powers and the corrected step.
// A gradient item reads the moments of its slot, updates and writes them
// back, and returns the new parameter value.
// One item is in work at a time. Loss and gradient items use the shared
// 64-step divider and 41-step square root and a four-step 64 x 64 multiplier.
// Moments live in one synchronous memory with per-slot valid bits; reset
// and restart clear the valid bits at once, no clearing pass.
// A finished result waits in the output register while the next item is
// accepted; a stalled receiver holds the block only at the end of that item.
// Reset is synchronous and restores the register defaults.
// ----------------------------------------------------------------------------
module adam_parameter_update_core
   import apu_pkg::*;
#(
   parameter int MAX_PARAMS = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // loss_value[47:0], param_index[53:48], gradient[101:54], param_value[149:102]
   input  logic [151:0] req_tdata,
   // cmd[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // new_param[47:0], iteration[63:48]
   output logic [63:0]  rsp_tdata,
   // status[1:0]
   output logic [1:0]   rsp_tuser,
   input  logic         csr_write,
   input  logic [2:0]   csr_index,
   input  logic [46:0]  csr_data
);

   localparam int AW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

   typedef enum logic [16:0] {
      ST_IDLE   = 17'h00001,
      ST_LCHECK = 17'h00002,
      ST_LP1    = 17'h00004,
      ST_LP2    = 17'h00008,
      ST_LSQRT  = 17'h00010,
      ST_LMUL   = 17'h00020,
      ST_LDIV   = 17'h00040,
      ST_GSQ    = 17'h00080,
      ST_GM1    = 17'h00100,
      ST_GM2    = 17'h00200,
      ST_GV1    = 17'h00400,
      ST_GV2    = 17'h00800,
      ST_GSQRT  = 17'h01000,
      ST_GMUL   = 17'h02000,
      ST_GDIV   = 17'h04000,
      ST_DONE   = 17'h08000,
      ST_SPARE  = 17'h10000
   } state_type;

   state_type       state_ff, state_in;
   logic            start_ff, start_in;
   logic [46:0]     lr_ff, lr_in, tol_ff, tol_in;
   logic [31:0]     b1_ff, b1_in, b2_ff, b2_in;
   logic [15:0]     maxit_ff, maxit_in;
   logic [47:0]     prev_loss_ff, prev_loss_in;
   logic            prev_valid_ff, prev_valid_in;
   logic [15:0]     iter_ff, iter_in;
   logic [31:0]     p1_ff, p1_in, p2_ff, p2_in;
   logic [46:0]     step_ff, step_in;
   logic [MAX_PARAMS-1:0] valid_ff, valid_in;
   logic            rsp_valid_ff, rsp_valid_in;

   logic [47:0]     loss_ff, loss_in, grad_ff, grad_in, pval_ff, pval_in;
   logic [AW-1:0]   addr_ff, addr_in;
   logic [46:0]     g2_ff, g2_in, v_new_ff, v_new_in;
   logic [49:0]     t1_ff, t1_in;
   logic [47:0]     m_new_ff, m_new_in;
   logic [40:0]     s_ff, s_in;
   logic [41:0]     den_ff, den_in;
   logic [127:0]    prod_ff, prod_in;
   status_type      res_status_ff, res_status_in;
   logic [47:0]     res_np_ff, res_np_in;
   logic [1:0]      rsp_status_ff, rsp_status_in;
   logic [47:0]     rsp_np_ff, rsp_np_in;
   logic [15:0]     rsp_iter_ff, rsp_iter_in;

   logic [95:0]     mem [MAX_PARAMS];
   logic [95:0]     mem_q_ff;
   logic            vld_q_ff;
   logic            mem_we, mem_re;
   logic [AW-1:0]   rd_addr;

   logic            accept;
   logic [31:0]     idx32;
   logic            idx_ok;
   logic [47:0]     m_old, v_old, abs_g;
   logic [32:0]     omb1, omb2, d1, d2;
   logic [48:0]     diff, abs_diff;
   logic [49:0]     t2;
   logic [50:0]     m_sum, v_sum, res_sum;
   logic [48:0]     mag;

   logic            mul_go, mul_done;
   logic [63:0]     mul_a, mul_b;
   logic [127:0]    mul_prod;
   ds_req_type      ds_ctl;
   logic            ds_done;
   logic [127:0]    ds_dividend;
   logic [63:0]     ds_divisor, ds_result;
   logic [47:0]     ds_radicand;

   function automatic logic [47:0] abs48(input logic [47:0] x);
      return x[47] ? 48'(-x) : x;
   endfunction

   function automatic logic [49:0] floor_q32(input logic neg, input logic [127:0] p);
      logic [81:0] m;
      logic [81:0] sp;
      m  = {1'b0, p[80:0]};
      sp = neg ? 82'(-m) : m;
      return sp[81:32];
   endfunction

   function automatic logic [47:0] sat51(input logic [50:0] x);
      if (!x[50] && x[49:47] != 3'b000) return SAT_MAX;
      if (x[50] && x[49:47] != 3'b111) return SAT_MIN;
      return x[47:0];
   endfunction

   apu_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_go),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   apu_divsqrt u_divsqrt (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ds_ctl),
      .dividend (ds_dividend),
      .divisor  (ds_divisor),
      .radicand (ds_radicand),
      .done     (ds_done),
      .result   (ds_result)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign idx32      = 32'(req_tdata[53:48]);
   assign idx_ok     = idx32 < MAX_PARAMS;
   assign rd_addr    = idx32[AW-1:0];
   assign mem_re     = accept;
   assign mem_we     = (state_ff == ST_GSQRT) && start_ff;

   assign m_old    = vld_q_ff ? mem_q_ff[47:0] : '0;
   assign v_old    = vld_q_ff ? mem_q_ff[95:48] : '0;
   assign abs_g    = abs48(grad_ff);
   assign omb1     = Q_ONE - {1'b0, b1_ff};
   assign omb2     = Q_ONE - {1'b0, b2_ff};
   assign d1       = Q_ONE - {1'b0, p1_ff};
   assign d2       = Q_ONE - {1'b0, p2_ff};
   assign diff     = {prev_loss_ff[47], prev_loss_ff} - {loss_ff[47], loss_ff};
   assign abs_diff = diff[48] ? 49'(-diff) : diff;
   assign t2       = floor_q32(grad_ff[47], mul_prod);
   assign m_sum    = {t1_ff[49], t1_ff} + {t2[49], t2};
   assign v_sum    = {1'b0, t1_ff} + {1'b0, mul_prod[81:32]};
   assign mag      = (ds_result > 64'(MAG_LIMIT)) ? MAG_LIMIT : ds_result[48:0];
   assign res_sum  = m_new_ff[47]
                   ? {{3{pval_ff[47]}}, pval_ff} + {2'b00, mag}
                   : {{3{pval_ff[47]}}, pval_ff} - {2'b00, mag};

   always_comb begin
      mul_a       = '0;
      mul_b       = '0;
      mul_go      = 1'b0;
      ds_ctl      = '{start: 1'b0, op: DS_SQRT};
      ds_dividend = prod_ff;
      ds_divisor  = '0;
      ds_radicand = '0;
      unique case (state_ff)
         ST_LP1: begin
            mul_a = 64'(p1_ff);
            mul_b = 64'(b1_ff);
            mul_go = start_ff;
         end
         ST_LP2: begin
            mul_a = 64'(p2_ff);
            mul_b = 64'(b2_ff);
            mul_go = start_ff;
         end
         ST_LMUL: begin
            mul_a = 64'(lr_ff);
            mul_b = 64'(s_ff);
            mul_go = start_ff;
         end
         ST_GSQ: begin
            mul_a = 64'(abs_g);
            mul_b = 64'(abs_g);
            mul_go = start_ff;
         end
         ST_GM1: begin
            mul_a = 64'(abs48(m_old));
            mul_b = 64'(b1_ff);
            mul_go = start_ff;
         end
         ST_GM2: begin
            mul_a = 64'(abs_g);
            mul_b = 64'(omb1);
            mul_go = start_ff;
         end
         ST_GV1: begin
            mul_a = 64'(v_old);
            mul_b = 64'(b2_ff);
            mul_go = start_ff;
         end
         ST_GV2: begin
            mul_a = 64'(g2_ff);
            mul_b = 64'(omb2);
            mul_go = start_ff;
         end
         ST_GMUL: begin
            mul_a = 64'(step_ff);
            mul_b = 64'(abs48(m_new_ff));
            mul_go = start_ff;
         end
         ST_LSQRT: begin
            ds_radicand = 48'(d2);
            ds_ctl = '{start: start_ff, op: DS_SQRT};
         end
         ST_GSQRT: begin
            ds_radicand = {1'b0, v_new_ff};
            ds_ctl = '{start: start_ff, op: DS_SQRT};
         end
         ST_LDIV: begin
            ds_divisor = 64'(d1);
            ds_ctl = '{start: start_ff, op: DS_DIV};
         end
         ST_GDIV: begin
            ds_divisor = 64'(den_ff);
            ds_ctl = '{start: start_ff, op: DS_DIV};
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      start_in      = 1'b0;
      lr_in         = lr_ff;
      tol_in        = tol_ff;
      b1_in         = b1_ff;
      b2_in         = b2_ff;
      maxit_in      = maxit_ff;
      prev_loss_in  = prev_loss_ff;
      prev_valid_in = prev_valid_ff;
      iter_in       = iter_ff;
      p1_in         = p1_ff;
      p2_in         = p2_ff;
      step_in       = step_ff;
      valid_in      = valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      loss_in       = loss_ff;
      grad_in       = grad_ff;
      pval_in       = pval_ff;
      addr_in       = addr_ff;
      g2_in         = g2_ff;
      v_new_in      = v_new_ff;
      t1_in         = t1_ff;
      m_new_in      = m_new_ff;
      s_in          = s_ff;
      den_in        = den_ff;
      prod_in       = prod_ff;
      res_status_in = res_status_ff;
      res_np_in     = res_np_ff;
      rsp_status_in = rsp_status_ff;
      rsp_np_in     = rsp_np_ff;
      rsp_iter_in   = rsp_iter_ff;

      if (csr_write) begin
         unique case (csr_index)
            CSR_LEARNING_RATE:  lr_in    = csr_data;
            CSR_TOLERANCE:      tol_in   = csr_data;
            CSR_FIRST_DECAY:    b1_in    = csr_data[31:0];
            CSR_SECOND_DECAY:   b2_in    = csr_data[31:0];
            CSR_MAX_ITERATIONS: maxit_in = csr_data[15:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               loss_in       = req_tdata[47:0];
               grad_in       = req_tdata[101:54];
               pval_in       = req_tdata[149:102];
               addr_in       = rd_addr;
               res_status_in = STATUS_CONTINUE;
               res_np_in     = '0;
               state_in      = ST_DONE;
               unique case (req_tuser)
                  CMD_RESTART: begin
                     valid_in      = '0;
                     prev_loss_in  = '0;
                     prev_valid_in = 1'b0;
                     iter_in       = '0;
                     p1_in         = POWER_ONE;
                     p2_in         = POWER_ONE;
                     step_in       = '0;
                  end
                  CMD_LOSS: begin
                     state_in = ST_LCHECK;
                  end
                  CMD_GRAD: begin
                     if (idx_ok) begin
                        state_in = ST_GSQ;
                        start_in = 1'b1;
                     end else begin
                        res_np_in = req_tdata[149:102];
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_LCHECK: begin
            if (iter_ff >= maxit_ff) begin
               res_status_in = STATUS_LIMIT;
               state_in      = ST_DONE;
            end else if (prev_valid_ff && abs_diff < {2'b00, tol_ff}) begin
               res_status_in = STATUS_CONVERGED;
               state_in      = ST_DONE;
            end else begin
               prev_loss_in  = loss_ff;
               prev_valid_in = 1'b1;
               iter_in       = iter_ff + 16'd1;
               state_in      = ST_LP1;
               start_in      = 1'b1;
            end
         end
         ST_LP1: begin
            if (mul_done) begin
               p1_in    = mul_prod[63:32];
               state_in = ST_LP2;
               start_in = 1'b1;
            end
         end
         ST_LP2: begin
            if (mul_done) begin
               p2_in    = mul_prod[63:32];
               state_in = ST_LSQRT;
               start_in = 1'b1;
            end
         end
         ST_LSQRT: begin
            if (ds_done) begin
               s_in     = ds_result[40:0];
               state_in = ST_LMUL;
               start_in = 1'b1;
            end
         end
         ST_LMUL: begin
            if (mul_done) begin
               prod_in  = mul_prod;
               state_in = ST_LDIV;
               start_in = 1'b1;
            end
         end
         ST_LDIV: begin
            if (ds_done) begin
               step_in  = (ds_result > 64'(SAT_MAX)) ? SAT_MAX[46:0] : ds_result[46:0];
               state_in = ST_DONE;
            end
         end
         ST_GSQ: begin
            if (mul_done) begin
               g2_in    = (mul_prod[95:79] != '0) ? SAT_MAX[46:0] : mul_prod[78:32];
               state_in = ST_GM1;
               start_in = 1'b1;
            end
         end
         ST_GM1: begin
            if (mul_done) begin
               t1_in    = floor_q32(m_old[47], mul_prod);
               state_in = ST_GM2;
               start_in = 1'b1;
            end
         end
         ST_GM2: begin
            if (mul_done) begin
               m_new_in = sat51(m_sum);
               state_in = ST_GV1;
               start_in = 1'b1;
            end
         end
         ST_GV1: begin
            if (mul_done) begin
               t1_in    = mul_prod[81:32];
               state_in = ST_GV2;
               start_in = 1'b1;
            end
         end
         ST_GV2: begin
            if (mul_done) begin
               v_new_in = (v_sum > 51'(SAT_MAX)) ? SAT_MAX[46:0] : v_sum[46:0];
               state_in = ST_GSQRT;
               start_in = 1'b1;
            end
         end
         ST_GSQRT: begin
            if (start_ff) begin
               valid_in[addr_ff] = 1'b1;
            end
            if (ds_done) begin
               den_in   = {1'b0, ds_result[40:0]} + EPS_Q;
               state_in = ST_GMUL;
               start_in = 1'b1;
            end
         end
         ST_GMUL: begin
            if (mul_done) begin
               prod_in  = mul_prod;
               state_in = ST_GDIV;
               start_in = 1'b1;
            end
         end
         ST_GDIV: begin
            if (ds_done) begin
               res_np_in = sat51(res_sum);
               state_in  = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_np_in     = res_np_ff;
               rsp_iter_in   = iter_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         start_ff      <= 1'b0;
         lr_ff         <= LR_RESET;
         tol_ff        <= TOL_RESET;
         b1_ff         <= B1_RESET;
         b2_ff         <= B2_RESET;
         maxit_ff      <= MAXIT_RESET;
         prev_loss_ff  <= '0;
         prev_valid_ff <= 1'b0;
         iter_ff       <= '0;
         p1_ff         <= POWER_ONE;
         p2_ff         <= POWER_ONE;
         step_ff       <= '0;
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         start_ff      <= start_in;
         lr_ff         <= lr_in;
         tol_ff        <= tol_in;
         b1_ff         <= b1_in;
         b2_ff         <= b2_in;
         maxit_ff      <= maxit_in;
         prev_loss_ff  <= prev_loss_in;
         prev_valid_ff <= prev_valid_in;
         iter_ff       <= iter_in;
         p1_ff         <= p1_in;
         p2_ff         <= p2_in;
         step_ff       <= step_in;
         valid_ff      <= valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      loss_ff       <= loss_in;
      grad_ff       <= grad_in;
      pval_ff       <= pval_in;
      addr_ff       <= addr_in;
      g2_ff         <= g2_in;
      v_new_ff      <= v_new_in;
      t1_ff         <= t1_in;
      m_new_ff      <= m_new_in;
      s_ff          <= s_in;
      den_ff        <= den_in;
      prod_ff       <= prod_in;
      res_status_ff <= res_status_in;
      res_np_ff     <= res_np_in;
      rsp_status_ff <= rsp_status_in;
      rsp_np_ff     <= rsp_np_in;
      rsp_iter_ff   <= rsp_iter_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr_ff] <= {1'b0, v_new_ff, m_new_ff};
      end
      if (mem_re) begin
         mem_q_ff <= mem[rd_addr];
         vld_q_ff <= valid_ff[rd_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_iter_ff, rsp_np_ff};
   assign rsp_tuser  = rsp_status_ff;

`ifndef SYNTHESIS
   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_tuser == CMD_RESTART |=> valid_ff == '0)
      else $error("restart left slot valid bits set");

   a_iter_step: assert property (@(posedge clock) disable iff (reset)
      iter_ff != $past(iter_ff) |-> (iter_ff == $past(iter_ff) + 16'd1 || iter_ff == '0))
      else $error("iteration count moved by more than one");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result loaded outside the done state");
`endif

endmodule

// ----- verif/tb_adam_parameter_update_core.sv -----
// ----------------------------------------------------------------------------
// tb_adam_parameter_update_core
// Self-checking bench for the Adam parameter update core.
//
// A queue of pending items, register writes, phase switches and pauses feeds
// a driver at the falling edge. A monitor at the rising edge runs an own
// Adam predictor on every accepted item and compares each result item with
// the oldest expected one. Sender idling and receiver stalls vary by phase.
// ----------------------------------------------------------------------------
module tb_adam_parameter_update_core;
   import apu_pkg::*;

   localparam int        NSLOTS  = 64;
   localparam longint    MAX47   = 64'h7FFF_FFFF_FFFF;
   localparam longint    MIN47   = -64'sh8000_0000_0000;
   localparam logic [32:0] ONE32 = 33'h1_0000_0000;

   typedef enum logic [1:0] {E_ITEM, E_CSR, E_PHASE, E_PAUSE} entry_kind_type;

   typedef struct {
      entry_kind_type kind;
      logic [1:0]     cmd;
      logic [47:0]    loss;
      logic [5:0]     slot;
      logic [47:0]    grad;
      logic [47:0]    pval;
      csr_index_type  idx;
      logic [46:0]    value;
      int             idle_pct;
      int             stall_pct;
   } entry_type;

   typedef struct {
      status_type  status;
      logic [47:0] new_param;
      logic [15:0] iteration;
   } result_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   // loss_value[47:0], param_index[53:48], gradient[101:54], param_value[149:102]
   logic [151:0] req_tdata;
   // cmd[1:0]
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   // new_param[47:0], iteration[63:48]
   logic [63:0]  rsp_tdata;
   // status[1:0]
   logic [1:0]   rsp_tuser;
   logic         csr_write;
   logic [2:0]   csr_index;
   logic [46:0]  csr_data;

   entry_type  pending[$];
   result_type expected_results[$];
   int         mismatches;
   int         idle_pct;
   int         stall_pct;
   bit         req_taken;

   logic [46:0] learning_rate;
   logic [46:0] tolerance;
   logic [31:0] first_decay;
   logic [31:0] second_decay;
   logic [15:0] max_iterations;
   logic signed [47:0] first_moment[NSLOTS];
   logic signed [47:0] second_moment[NSLOTS];
   longint      previous_loss;
   bit          previous_loss_valid;
   logic [15:0] iteration_count;
   logic [63:0] first_power;
   logic [63:0] second_power;
   logic [63:0] corrected_step;

   adam_parameter_update_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   function automatic logic [63:0] root_q32(input logic [127:0] x);
      logic [63:0]  r;
      logic [127:0] c;
      r = 0;
      for (int b = 40; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if (c * c <= x) r = c[63:0];
      end
      return r;
   endfunction

   function automatic longint clamp48(input logic signed [127:0] x);
      if (x > MAX47) return MAX47;
      if (x < MIN47) return MIN47;
      return longint'(x);
   endfunction

   function automatic logic signed [127:0] scale_q32(input longint x, input logic [32:0] b);
      logic signed [127:0] xs;
      logic signed [127:0] bs;
      xs = x;
      bs = {95'd0, b};
      return (xs * bs) >>> 32;
   endfunction

   function automatic void clear_optimizer();
      for (int i = 0; i < NSLOTS; i++) begin
         first_moment[i]  = 0;
         second_moment[i] = 0;
      end
      previous_loss       = 0;
      previous_loss_valid = 0;
      iteration_count     = 0;
      first_power         = 64'hFFFF_FFFF;
      second_power        = 64'hFFFF_FFFF;
      corrected_step      = 0;
   endfunction

   function automatic status_type advance_loss(input logic [47:0] loss_bits);
      longint       loss;
      longint       diff;
      logic [127:0] quot;
      logic [63:0]  step_root;
      loss = longint'($signed(loss_bits));
      if (iteration_count >= max_iterations) return STATUS_LIMIT;
      if (previous_loss_valid) begin
         diff = previous_loss - loss;
         if (diff < 0) diff = -diff;
         if (diff < longint'({17'd0, tolerance})) return STATUS_CONVERGED;
      end
      previous_loss       = loss;
      previous_loss_valid = 1;
      iteration_count     = iteration_count + 16'd1;
      first_power  = (first_power * first_decay) >> 32;
      second_power = (second_power * second_decay) >> 32;
      step_root = root_q32({64'd0, 64'(ONE32) - second_power} << 32);
      quot = ({81'd0, learning_rate} * {64'd0, step_root}) /
             {64'd0, 64'(ONE32) - first_power};
      corrected_step = (quot > MAX47) ? 64'(MAX47) : quot[63:0];
      return STATUS_CONTINUE;
   endfunction

   function automatic logic [47:0] adam_update(input logic [5:0] slot,
                                               input logic [47:0] grad_bits,
                                               input logic [47:0] pval_bits);
      longint       g;
      longint       ag;
      longint       g2;
      longint       m;
      longint       v;
      longint       am;
      logic [127:0] sq;
      logic [127:0] quot;
      logic [63:0]  den;
      g  = longint'($signed(grad_bits));
      ag = (g < 0) ? -g : g;
      sq = ({64'd0, ag} * {64'd0, ag}) >> 32;
      g2 = (sq > MAX47) ? MAX47 : longint'(sq);
      m = clamp48(scale_q32(longint'(first_moment[slot]), {1'b0, first_decay}) +
                  scale_q32(g, ONE32 - first_decay));
      v = clamp48(scale_q32(longint'(second_moment[slot]), {1'b0, second_decay}) +
                  scale_q32(g2, ONE32 - second_decay));
      if (v < 0) v = 0;
      first_moment[slot]  = 48'(m);
      second_moment[slot] = 48'(v);
      den  = root_q32({64'd0, v} << 32) + 64'd43;
      am   = (m < 0) ? -m : m;
      quot = ({64'd0, corrected_step} * {64'd0, am}) / {64'd0, den};
      if (quot > 128'h1_0000_0000_0000) quot = 128'h1_0000_0000_0000;
      if (m < 0)
         return 48'(clamp48(longint'($signed(pval_bits)) + longint'(quot)));
      return 48'(clamp48(longint'($signed(pval_bits)) - longint'(quot)));
   endfunction

   function automatic result_type predict_result(input entry_type e);
      result_type r;
      r.status    = STATUS_CONTINUE;
      r.new_param = 0;
      case (e.cmd)
         CMD_RESTART: clear_optimizer();
         CMD_LOSS:    r.status = advance_loss(e.loss);
         CMD_GRAD:    r.new_param = adam_update(e.slot, e.grad, e.pval);
         default:     ;
      endcase
      r.iteration = iteration_count;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   always @(posedge clock) begin
      result_type want;
      entry_type  e;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected item", rsp_tdata, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_tuser !== want.status)
                  report_mismatch("status", rsp_tuser, want.status);
               if (rsp_tdata[47:0] !== want.new_param)
                  report_mismatch("new_param", rsp_tdata[47:0], want.new_param);
               if (rsp_tdata[63:48] !== want.iteration)
                  report_mismatch("iteration", rsp_tdata[63:48], want.iteration);
            end
         end
         if (req_tvalid && req_tready && !req_taken) begin
            e.cmd  = req_tuser;
            e.loss = req_tdata[47:0];
            e.slot = req_tdata[53:48];
            e.grad = req_tdata[101:54];
            e.pval = req_tdata[149:102];
            expected_results.push_back(predict_result(e));
            req_taken = 1;
         end
      end
   end

   always @(negedge clock) begin
      entry_type e;
      bit        valid_n;
      bit        write_n;
      bit        scanning;
      valid_n  = req_tvalid;
      write_n  = 0;
      if (!reset && !(req_tvalid && !req_taken)) begin
         valid_n  = 0;
         scanning = 1;
         while (scanning && pending.size() > 0) begin
            e = pending[0];
            case (e.kind)
               E_PHASE: begin
                  idle_pct  = e.idle_pct;
                  stall_pct = e.stall_pct;
                  void'(pending.pop_front());
               end
               E_PAUSE: begin
                  if (expected_results.size() == 0) void'(pending.pop_front());
                  else scanning = 0;
               end
               E_CSR: begin
                  if (expected_results.size() == 0) begin
                     case (e.idx)
                        CSR_LEARNING_RATE: learning_rate  = e.value;
                        CSR_TOLERANCE:     tolerance      = e.value;
                        CSR_FIRST_DECAY:   first_decay    = e.value[31:0];
                        CSR_SECOND_DECAY:  second_decay   = e.value[31:0];
                        default:           max_iterations = e.value[15:0];
                     endcase
                     csr_index <= e.idx;
                     csr_data  <= e.value;
                     write_n = 1;
                     void'(pending.pop_front());
                  end
                  scanning = 0;
               end
               default: begin
                  if ($urandom_range(99) >= idle_pct) begin
                     req_tuser <= e.cmd;
                     req_tdata <= {2'b00, e.pval, e.grad, e.slot, e.loss};
                     valid_n   = 1;
                     req_taken = 0;
                     void'(pending.pop_front());
                  end
                  scanning = 0;
               end
            endcase
         end
      end
      req_tvalid <= valid_n;
      csr_write  <= write_n;
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic logic [47:0] rand_q(input int kind);
      logic [47:0] x;
      x = 48'({$urandom, $urandom});
      case (kind)
         0: return x;
         1: return 48'($signed(x) >>> $urandom_range(47, 8));
         default: return 48'($signed(x) >>> $urandom_range(47, 30));
      endcase
   endfunction

   task automatic add_item(input logic [1:0] cmd, input logic [47:0] loss,
                           input logic [5:0] slot, input logic [47:0] grad,
                           input logic [47:0] pval);
      entry_type e;
      e.kind = E_ITEM;
      e.cmd  = cmd;
      e.loss = loss;
      e.slot = slot;
      e.grad = grad;
      e.pval = pval;
      pending.push_back(e);
   endtask

   task automatic add_csr(input csr_index_type idx, input logic [46:0] value);
      entry_type e;
      e.kind  = E_CSR;
      e.idx   = idx;
      e.value = value;
      pending.push_back(e);
   endtask

   initial begin
      entry_type e;
      int        r;
      clock           = 0;
      reset           = 1;
      req_tvalid      = 0;
      req_tdata       = 0;
      req_tuser       = CMD_RESTART;
      rsp_tready      = 0;
      csr_write       = 0;
      csr_index       = CSR_LEARNING_RATE;
      csr_data        = 0;
      mismatches      = 0;
      idle_pct        = 0;
      stall_pct       = 0;
      req_taken       = 1;
      learning_rate   = LR_RESET;
      tolerance       = TOL_RESET;
      first_decay     = B1_RESET;
      second_decay    = B2_RESET;
      max_iterations  = MAXIT_RESET;
      clear_optimizer();

      // directed: defaults
      add_item(CMD_GRAD, 0, 6'd0, 48'h0001_0000_0000, 48'h0000_8000_0000);
      add_item(CMD_LOSS, 48'h0000_0010_0000, 0, 0, 0);
      add_item(CMD_LOSS, 48'h0000_0010_0001, 0, 0, 0);
      add_item(CMD_LOSS, 48'h8000_0000_0000, 0, 0, 0);
      add_item(CMD_GRAD, 0, 6'd63, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF);
      add_item(CMD_GRAD, 0, 6'd63, 48'h8000_0000_0000, 48'h8000_0000_0000);
      add_item(CMD_GRAD, 0, 6'd1, 48'hFFFF_FFFF_FFFF, 0);
      add_item(CMD_GRAD, 0, 6'd1, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF);
      add_item(CMD_LOSS, 48'h7FFF_FFFF_FFFF, 0, 0, 0);
      add_item(2'd3, 48'hFFFF_FFFF_FFFF, 6'd63, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
      add_item(CMD_RESTART, 0, 0, 0, 0);
      add_item(CMD_GRAD, 0, 6'd2, 48'h0000_4000_0000, 48'h0001_0000_0000);
      // directed: zero limit and extremes
      e.kind = E_PAUSE;
      pending.push_back(e);
      add_csr(CSR_MAX_ITERATIONS, 47'd0);
      add_csr(CSR_LEARNING_RATE, 47'h7FFF_FFFF_FFFF);
      add_csr(CSR_TOLERANCE, 47'h7FFF_FFFF_FFFF);
      add_csr(CSR_FIRST_DECAY, 47'd0);
      add_csr(CSR_SECOND_DECAY, 47'hFFFF_FFFF);
      add_item(CMD_LOSS, 48'h0000_0001_0000, 0, 0, 0);
      add_csr(CSR_MAX_ITERATIONS, 47'hFFFF);
      add_item(CMD_LOSS, 48'h0000_0001_0000, 0, 0, 0);
      add_item(CMD_LOSS, 48'h8000_0000_0000, 0, 0, 0);
      add_item(CMD_GRAD, 0, 6'd5, 48'h7FFF_FFFF_FFFF, 0);
      add_item(CMD_GRAD, 0, 6'd5, 48'h8000_0000_0000, 0);
      add_csr(CSR_FIRST_DECAY, 47'hFFFF_FFFF);
      add_csr(CSR_SECOND_DECAY, 47'd0);
      add_csr(CSR_TOLERANCE, 47'd0);
      add_item(CMD_LOSS, 48'h0000_0002_0000, 0, 0, 0);
      add_item(CMD_GRAD, 0, 6'd6, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF);

      for (int ph = 0; ph < 5; ph++) begin
         e.kind      = E_PHASE;
         e.idle_pct  = (ph == 1 || ph == 4) ? 73 : (ph == 3 ? 38 : 0);
         e.stall_pct = (ph == 2 || ph == 4) ? 73 : (ph == 3 ? 38 : 0);
         pending.push_back(e);
         e.kind = E_PAUSE;
         pending.push_back(e);
         add_csr(CSR_LEARNING_RATE, (ph == 4) ? 47'h7FFF_FFFF_FFFF :
                 47'(rand_q($urandom_range(2)) & 48'h3FFF_FFFF_FFFF));
         add_csr(CSR_TOLERANCE, (ph == 0) ? 47'd0 : 47'({$urandom} >> $urandom_range(31, 8)));
         add_csr(CSR_FIRST_DECAY, (ph == 1) ? 47'hFFFF_FFFF : 47'($urandom));
         add_csr(CSR_SECOND_DECAY, (ph == 2) ? 47'd0 : 47'($urandom));
         add_csr(CSR_MAX_ITERATIONS, (ph == 3) ? 47'hFFFF : 47'($urandom_range(60, 1)));
         add_item(CMD_RESTART, rand_q(0), 0, 0, 0);
         for (int i = 0; i < 145; i++) begin
            r = $urandom_range(99);
            if (r < 30)
               add_item(CMD_LOSS, rand_q($urandom_range(2)), 6'($urandom), 0, 0);
            else if (r < 92)
               add_item(CMD_GRAD, rand_q(0), 6'($urandom_range(NSLOTS - 1)),
                        rand_q($urandom_range(2)), rand_q($urandom_range(2)));
            else if (r < 96)
               add_item(CMD_RESTART, rand_q(0), 6'($urandom), rand_q(0), rand_q(0));
            else
               add_item(2'd3, rand_q(0), 6'($urandom), rand_q(0), rand_q(0));
         end
      end

      repeat (5) @(posedge clock);
      reset <= 0;
      wait (pending.size() == 0 && req_taken && expected_results.size() == 0);
      repeat (200) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #(8 * 3_000_000);
      $display("FAILURE");
      $finish;
   end

endmodule
